@@ rtl/core/chwm_pkg.sv @@
package chwm_pkg;

    localparam int BIN_COUNT          = 64;
    localparam int BIN_WIDTH          = 16;
    localparam int MEAN_FRACTION_BITS = 8;

    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 16;
    localparam int BINO_W  = 16;
    localparam int MEAN_W  = 14;
    localparam int TOTAL_W = 32;
    localparam int SHOT_W  = 16;

    localparam int IDX_W = $clog2(BIN_COUNT);
    localparam int WS_W  = TOTAL_W + IDX_W;
    localparam int Q_W   = IDX_W + MEAN_FRACTION_BITS;
    localparam int QX_W  = (Q_W > MEAN_W) ? Q_W : MEAN_W;
    localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_RECORD = 2'd1,
        FUNC_READ   = 2'd2
    } t_func;

    typedef struct packed {
        logic latch;
        logic upd;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_sts;

endpackage

@@ rtl/core/chwm_in_if.sv @@
interface chwm_in_if import chwm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output func, output value, output last, input ready);
    modport sink   (input valid, input func, input value, input last, output ready);
endinterface

@@ rtl/core/chwm_out_if.sv @@
interface chwm_out_if import chwm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BINO_W-1:0]  bin_count;
    logic [MEAN_W-1:0]  mean_fixed;
    logic [TOTAL_W-1:0] in_range_total;
    logic [SHOT_W-1:0]  shots_in_batch;
    logic               out_of_range;

    modport source (output valid, output bin_count, output mean_fixed,
                    output in_range_total, output shots_in_batch,
                    output out_of_range, input ready);
    modport sink   (input valid, input bin_count, input mean_fixed,
                    input in_range_total, input shots_in_batch,
                    input out_of_range, output ready);
endinterface

@@ rtl/core/count_histogram_with_mean.sv @@
// channel  dir  modport  payload
// i_in     in   sink     func[1:0] value[15:0] last
// o_out    out  source   bin_count[15:0] mean_fixed[13:0] in_range_total[31:0]
//                        shots_in_batch[15:0] out_of_range
//
// One request at a time. Clear, read, unused func, and a record that leaves the
// bins unchanged pass through read, update and done; a record that bumps a bin
// also runs the bit-serial mean divider (IDX_W + MEAN_FRACTION_BITS steps).
// Synchronous active-low reset; bin valid bits clear at once, no clearing pass.
// A finished result waits in the output register while the next request is
// taken; a request completes only once that register is free.
module count_histogram_with_mean import chwm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chwm_in_if.sink    i_in,
    chwm_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    chwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    chwm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_func           (i_in.func),
        .i_value          (i_in.value),
        .i_last           (i_in.last),
        .o_bin_count      (o_out.bin_count),
        .o_mean_fixed     (o_out.mean_fixed),
        .o_in_range_total (o_out.in_range_total),
        .o_shots_in_batch (o_out.shots_in_batch),
        .o_out_of_range   (o_out.out_of_range)
    );

endmodule

@@ rtl/core/chwm_ctrl.sv @@
module chwm_ctrl import chwm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_DIV    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign out_free    = !r_ovalid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.load_out) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_ovalid || i_out_ready))
        else $error("pending result overwritten");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && i_sts.need_div) |=> ##(Q_W-1)
        (r_state == S_DIV && i_sts.div_done))
        else $error("divider step count wrong");
`endif

endmodule

@@ rtl/core/chwm_dp.sv @@
module chwm_dp import chwm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_last,
    output logic [BINO_W-1:0]  o_bin_count,
    output logic [MEAN_W-1:0]  o_mean_fixed,
    output logic [TOTAL_W-1:0] o_in_range_total,
    output logic [SHOT_W-1:0]  o_shots_in_batch,
    output logic               o_out_of_range
);

    localparam logic [BIN_WIDTH-1:0] BIN_MAX = '1;

    // request latch
    logic [FUNC_W-1:0]  r_func;
    logic [VALUE_W-1:0] r_value;
    logic               r_last;

    // bin memory, valid bit per entry gives the cleared value
    logic [BIN_WIDTH-1:0] r_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] r_vld;
    logic [BIN_WIDTH-1:0] r_rd_data;
    logic                 r_rd_vld;

    logic [TOTAL_W-1:0] r_total;
    logic [WS_W-1:0]    r_wsum;
    logic [SHOT_W-1:0]  r_batch;
    logic [SHOT_W-1:0]  r_last_size;
    logic [MEAN_W-1:0]  r_mean;
    logic [BINO_W-1:0]  r_bin_out;
    logic               r_oor;

    // divider
    logic [TOTAL_W-1:0] r_rem;
    logic [TOTAL_W-1:0] r_dvs;
    logic [Q_W-1:0]     r_dsh;
    logic [Q_W-1:0]     r_quo;
    logic [CNT_W-1:0]   r_dcnt;

    // output register
    logic [BINO_W-1:0]  r_o_bin;
    logic [MEAN_W-1:0]  r_o_mean;
    logic [TOTAL_W-1:0] r_o_total;
    logic [SHOT_W-1:0]  r_o_shots;
    logic               r_o_oor;

    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [BIN_WIDTH-1:0] bin_cur;
    logic               is_clr, is_rec, is_rd;
    logic               can_inc;
    logic [TOTAL_W-1:0] n_total;
    logic [WS_W-1:0]    n_wsum;
    logic [SHOT_W-1:0]  n_batch;
    logic [TOTAL_W:0]   trial;
    logic [TOTAL_W:0]   diff;
    logic               ge;
    logic [Q_W-1:0]     n_quo;
    logic [QX_W-1:0]    quo_x;
    logic               div_done;

    always_comb begin
        idx      = r_value[IDX_W-1:0];
        in_range = r_value < VALUE_W'(BIN_COUNT);
        bin_cur  = r_rd_vld ? r_rd_data : '0;
        is_clr   = (r_func == FUNC_CLEAR);
        is_rec   = (r_func == FUNC_RECORD);
        is_rd    = (r_func == FUNC_READ);
        can_inc  = is_rec && in_range && (bin_cur != BIN_MAX) && (r_total != '1);
        n_total  = r_total + 1'b1;
        n_wsum   = r_wsum + WS_W'(idx);
        n_batch  = (r_batch != '1) ? r_batch + 1'b1 : r_batch;

        trial    = {r_rem, r_dsh[Q_W-1]};
        diff     = trial - {1'b0, r_dvs};
        ge       = trial >= {1'b0, r_dvs};
        n_quo    = Q_W'({r_quo, ge});
        quo_x    = QX_W'(n_quo);
        div_done = (r_dcnt == CNT_W'(Q_W-1));
    end

    assign o_sts.need_div = can_inc;
    assign o_sts.div_done = div_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= i_func;
            r_value <= i_value;
            r_last  <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[idx];
        if (i_cmd.upd && can_inc) begin
            r_mem[idx] <= bin_cur + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[idx];
            if (i_cmd.upd && is_clr) begin
                r_vld <= '0;
            end else if (i_cmd.upd && can_inc) begin
                r_vld[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_wsum      <= '0;
            r_batch     <= '0;
            r_last_size <= '0;
            r_mean      <= '0;
            r_dcnt      <= '0;
        end else if (i_cmd.upd) begin
            if (is_clr) begin
                r_total     <= '0;
                r_wsum      <= '0;
                r_batch     <= '0;
                r_last_size <= '0;
                r_mean      <= '0;
            end else if (is_rec) begin
                if (r_last) begin
                    r_last_size <= n_batch;
                    r_batch     <= '0;
                end else begin
                    r_batch <= n_batch;
                end
                if (can_inc) begin
                    r_total <= n_total;
                    r_wsum  <= n_wsum;
                    r_dcnt  <= '0;
                end
            end
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (div_done) begin
                r_mean <= (quo_x > QX_W'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(quo_x);
            end
        end
    end

    // restoring division of (wsum << frac) by total, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_bin_out <= (is_rd && in_range) ? BINO_W'(bin_cur) : '0;
            r_oor     <= is_rec && !in_range;
            r_rem     <= n_wsum[WS_W-1:IDX_W];
            r_dvs     <= n_total;
            r_dsh     <= Q_W'(n_wsum[IDX_W-1:0]) << MEAN_FRACTION_BITS;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
            r_dsh <= Q_W'({r_dsh, 1'b0});
            r_quo <= n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_bin   <= r_bin_out;
            r_o_mean  <= r_mean;
            r_o_total <= r_total;
            r_o_shots <= r_last_size;
            r_o_oor   <= r_oor;
        end
    end

    assign o_bin_count      = r_o_bin;
    assign o_mean_fixed     = r_o_mean;
    assign o_in_range_total = r_o_total;
    assign o_shots_in_batch = r_o_shots;
    assign o_out_of_range   = r_o_oor;

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");

    a_empty_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0) |-> (r_mean == '0))
        else $error("nonzero mean with empty histogram");
`endif

endmodule

@@ test/count_histogram_with_mean_checker.sv @@
module count_histogram_with_mean_checker import chwm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    chwm_in_if   i_req,
    chwm_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BINO_W-1:0]  bin_count;
        logic [MEAN_W-1:0]  mean_fixed;
        logic [TOTAL_W-1:0] in_range_total;
        logic [SHOT_W-1:0]  shots_in_batch;
        logic               out_of_range;
    } t_hist_stat;

    logic [BIN_WIDTH-1:0] hist_bin [BIN_COUNT];
    logic [TOTAL_W-1:0]   hist_total;
    logic [WS_W-1:0]      hist_wsum;
    logic [SHOT_W-1:0]    open_shots;
    logic [SHOT_W-1:0]    closed_shots;
    t_hist_stat           stat_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_histogram();
        foreach (hist_bin[i]) hist_bin[i] = '0;
        hist_total   = '0;
        hist_wsum    = '0;
        open_shots   = '0;
        closed_shots = '0;
    endfunction

    function automatic logic [MEAN_W-1:0] weighted_mean();
        logic [63:0] quot;
        if (hist_total == '0) return '0;
        quot = (64'(hist_wsum) << MEAN_FRACTION_BITS) / 64'(hist_total);
        return (quot > 64'(MEAN_MAX)) ? MEAN_MAX : quot[MEAN_W-1:0];
    endfunction

    // Updates the histogram for one request and returns the status it reports.
    function automatic t_hist_stat apply_shot(logic [FUNC_W-1:0] func,
                                              logic [VALUE_W-1:0] value,
                                              logic last_flag);
        t_hist_stat stat;
        stat = '0;
        case (func)
            FUNC_CLEAR: begin
                clear_histogram();
            end
            FUNC_RECORD: begin
                if (open_shots != '1) open_shots++;
                if (value < BIN_COUNT) begin
                    if (hist_bin[value[IDX_W-1:0]] != '1 && hist_total != '1) begin
                        hist_bin[value[IDX_W-1:0]]++;
                        hist_total++;
                        hist_wsum += WS_W'(value);
                    end
                end else begin
                    stat.out_of_range = 1'b1;
                end
                if (last_flag) begin
                    closed_shots = open_shots;
                    open_shots   = '0;
                end
            end
            FUNC_READ: begin
                if (value < BIN_COUNT) stat.bin_count = hist_bin[value[IDX_W-1:0]];
            end
            default: ;
        endcase
        stat.mean_fixed     = weighted_mean();
        stat.in_range_total = hist_total;
        stat.shots_in_batch = closed_shots;
        return stat;
    endfunction

    always @(posedge i_clk) begin
        t_hist_stat got;
        t_hist_stat want;
        if (!i_rst_n) begin
            clear_histogram();
            stat_q.delete();
        end else begin
            // result first: it always belongs to an older request
            if (i_rsp.valid && i_rsp.ready) begin
                got.bin_count      = i_rsp.bin_count;
                got.mean_fixed     = i_rsp.mean_fixed;
                got.in_range_total = i_rsp.in_range_total;
                got.shots_in_batch = i_rsp.shots_in_batch;
                got.out_of_range   = i_rsp.out_of_range;
                if (stat_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("%0t: result with no request pending: bin %0d mean %0d",
                                 $time, got.bin_count, got.mean_fixed);
                    end
                end else begin
                    want = stat_q.pop_front();
                    if (got.bin_count !== want.bin_count
                            || got.mean_fixed !== want.mean_fixed
                            || got.in_range_total !== want.in_range_total
                            || got.shots_in_batch !== want.shots_in_batch
                            || got.out_of_range !== want.out_of_range) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch exp bin %0d mean %0d total %0d shots %0d oor %0b",
                                     $time, want.bin_count, want.mean_fixed,
                                     want.in_range_total, want.shots_in_batch,
                                     want.out_of_range);
                            $display("%0t:          got bin %0d mean %0d total %0d shots %0d oor %0b",
                                     $time, got.bin_count, got.mean_fixed,
                                     got.in_range_total, got.shots_in_batch,
                                     got.out_of_range);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                stat_q.push_back(apply_shot(i_req.func, i_req.value, i_req.last));
            end
        end
        o_pending = stat_q.size();
    end

endmodule

@@ test/count_histogram_with_mean_test.sv @@
module count_histogram_with_mean_test;
    import chwm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int BATCH_SHOTS  = 20;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_request   = 1'b0;
    int   quiet_cycles   = 0;
    int   fail_count;
    int   pending;

    chwm_in_if  shot_ch ();
    chwm_out_if stat_ch ();

    count_histogram_with_mean u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (shot_ch),
        .o_out   (stat_ch)
    );

    count_histogram_with_mean_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (shot_ch),
        .i_rsp        (stat_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 clk = ~clk;

    // result side: random stalls, plus a long hold-off on request
    initial begin
        stat_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                stat_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end else begin
                stat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((shot_ch.valid && shot_ch.ready) || (stat_ch.valid && stat_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_shot(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value,
                             logic last_flag);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            shot_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        shot_ch.valid <= 1'b1;
        shot_ch.func  <= func;
        shot_ch.value <= value;
        shot_ch.last  <= last_flag;
        do @(posedge clk); while (!shot_ch.ready);
    endtask

    task automatic send_random_shot();
        int                 pick;
        logic [VALUE_W-1:0] bin_sel;
        logic [VALUE_W-1:0] wide;
        pick    = $urandom_range(99);
        bin_sel = VALUE_W'($urandom_range(BIN_COUNT - 1));
        wide    = VALUE_W'($urandom_range(65535, BIN_COUNT));
        if (pick < 62) begin
            send_shot(FUNC_RECORD, bin_sel, $urandom_range(7) == 0);
        end else if (pick < 70) begin
            send_shot(FUNC_RECORD, wide, $urandom_range(3) == 0);
        end else if (pick < 88) begin
            send_shot(FUNC_READ, bin_sel, 1'($urandom_range(1)));
        end else if (pick < 93) begin
            send_shot(FUNC_READ, wide, 1'($urandom_range(1)));
        end else if (pick < 95) begin
            send_shot(FUNC_CLEAR, VALUE_W'($urandom), 1'($urandom_range(1)));
        end else begin
            send_shot(FUNC_UNUSED, VALUE_W'($urandom), 1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int shots, logic hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold) hold_request = 1'b1;
        repeat (shots) send_random_shot();
    endtask

    initial begin
        shot_ch.valid <= 1'b0;
        shot_ch.func  <= FUNC_CLEAR;
        shot_ch.value <= '0;
        shot_ch.last  <= 1'b0;
        rst_n         <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty histogram, bin edges, out-of-range values, ignored last flag
        send_shot(FUNC_READ,   16'd0,     1'b0);
        send_shot(FUNC_UNUSED, 16'hFFFF,  1'b1);
        send_shot(FUNC_RECORD, 16'd0,     1'b0);
        send_shot(FUNC_RECORD, 16'd63,    1'b0);
        send_shot(FUNC_RECORD, 16'd64,    1'b0);
        send_shot(FUNC_RECORD, 16'hFFFF,  1'b1);
        send_shot(FUNC_READ,   16'd63,    1'b0);
        send_shot(FUNC_READ,   16'd0,     1'b1);
        send_shot(FUNC_READ,   16'd64,    1'b0);
        send_shot(FUNC_READ,   16'hFFFF,  1'b0);
        send_shot(FUNC_CLEAR,  16'hFFFF,  1'b1);
        send_shot(FUNC_READ,   16'd63,    1'b0);
        send_shot(FUNC_RECORD, 16'd63,    1'b1);
        send_shot(FUNC_RECORD, 16'd1,     1'b0);
        send_shot(FUNC_RECORD, 16'h5555,  1'b0);
        send_shot(FUNC_RECORD, 16'hAAAA,  1'b1);
        send_shot(FUNC_UNUSED, 16'hAAAA,  1'b0);
        send_shot(FUNC_READ,   16'd1,     1'b0);

        // one longer batch into bin 0
        repeat (BATCH_SHOTS) send_shot(FUNC_RECORD, 16'd0, 1'b0);
        send_shot(FUNC_RECORD, 16'd0, 1'b1);
        send_shot(FUNC_READ,   16'd0, 1'b0);
        send_shot(FUNC_CLEAR,  16'd0, 1'b0);

        run_phase(0,  0,  300, 1'b1);
        run_phase(84, 0,  250, 1'b0);
        run_phase(0,  84, 250, 1'b0);
        run_phase(33, 33, 250, 1'b0);
        run_phase(0,  0,  250, 1'b0);

        shot_ch.valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
